@@ hdl/sbl_pkg.sv @@
// shared constants and types for the sobel edge threshold stream
package sbl_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int DIM_W      = 11;
  localparam int PIX_W      = 8;
  localparam int POS_W      = 10;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;

  localparam logic [DIM_W-1:0] DIM_MIN        = DIM_W'(3);
  localparam logic [DIM_W-1:0] WIDTH_MAX      = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] HEIGHT_MAX     = DIM_W'(MAX_HEIGHT);
  localparam logic [DIM_W-1:0] WIDTH_RESET    = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RESET   = DIM_W'(480);
  localparam logic [DIM_W-1:0] THRESH_RESET   = DIM_W'(128);

  localparam logic [PIX_W-1:0] EDGE_ON  = 8'hFF;
  localparam logic [PIX_W-1:0] EDGE_OFF = 8'h00;

  localparam logic [1:0] REG_FRAME_WIDTH    = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_EDGE_THRESHOLD = 2'd2;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1) + 1;

  typedef struct packed {
    logic [PIX_W-1:0] edge_value;
    logic [POS_W-1:0] center_column;
    logic [POS_W-1:0] center_row;
    logic             frame_end;
  } result_t;

endpackage

@@ hdl/sbl_result_fifo.sv @@
// small result queue that parts the compute pipeline from the output stall
module sbl_result_fifo import sbl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  result_t               push_data,
  input  logic                  pop_stall,
  output logic                  head_valid,
  output result_t               head_data,
  output logic [FIFO_CNT_W-1:0] count
);

  result_t               entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic                  pop;

  assign head_valid = (count != '0);
  assign head_data  = entries[rd_ptr];
  assign pop        = head_valid && !pop_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end
  end

endmodule

@@ hdl/sobel_edge_threshold_stream_top.sv @@
// top level of the streaming 3x3 sobel edge detector with threshold
// an accepted pixel beat is registered in s1, then, if it completes a window, in s2, then written into the result fifo
// throughput: one pixel per cycle while pixel_stall is low, with one read and one write port on the line store
// the line store is read in the accept cycle and written back in the following one
// reset: counters, window and stage valids clear, registers return to 640, 480 and 128
// reset: the line store is not cleared; only border reads see unwritten entries
module sobel_edge_threshold_stream_top import sbl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               pixel_valid,
  output logic               pixel_stall,
  input  logic [PIX_W-1:0]   gray_pixel,
  output logic               edge_valid,
  input  logic               edge_stall,
  output logic [PIX_W-1:0]   edge_value,
  output logic [POS_W-1:0]   center_column,
  output logic [POS_W-1:0]   center_row,
  output logic               frame_end,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  logic [DIM_W-1:0] edge_threshold;
  logic [DIM_W-1:0] width_eff;
  logic [DIM_W-1:0] height_eff;

  logic [DIM_W-1:0] column_count;
  logic [DIM_W-1:0] row_count;
  logic [DIM_W-1:0] column_count_next;
  logic [DIM_W-1:0] row_count_next;
  logic [DIM_W-1:0] col_adj;
  logic [DIM_W-1:0] row_adj;
  logic [DIM_W-1:0] row_tmp;
  logic [DIM_W-1:0] col_inc;
  logic [DIM_W-1:0] row_inc;
  logic             pixel_accept;

  logic [15:0] line_store [MAX_WIDTH];
  logic [15:0] line_rdata;

  logic               s1_valid;
  logic [PIX_W-1:0]   s1_pixel;
  logic [ADDR_W-1:0]  s1_addr;
  logic               s1_emit;
  logic [POS_W-1:0]   s1_col;
  logic [POS_W-1:0]   s1_row;
  logic               s1_end;

  logic [23:0] win_left;
  logic [23:0] win_centre;
  logic [23:0] new_col;
  logic [9:0]  sum_right;
  logic [9:0]  sum_left;
  logic [9:0]  sum_top;
  logic [9:0]  sum_bottom;
  logic signed [10:0] grad_x;
  logic signed [10:0] grad_y;

  logic               s2_valid;
  logic signed [10:0] s2_gx;
  logic signed [10:0] s2_gy;
  logic [POS_W-1:0]   s2_col;
  logic [POS_W-1:0]   s2_row;
  logic               s2_end;
  logic signed [10:0] neg_x;
  logic signed [10:0] neg_y;
  logic [9:0]         abs_x;
  logic [9:0]         abs_y;
  logic [DIM_W-1:0]   grad_sum;
  result_t            s2_result;

  logic [FIFO_CNT_W-1:0] fifo_count;
  logic [FIFO_CNT_W-1:0] in_flight;
  result_t               head_data;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= WIDTH_RESET;
      frame_height   <= HEIGHT_RESET;
      edge_threshold <= THRESH_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_FRAME_WIDTH:    frame_width    <= pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT:   frame_height   <= pwdata[DIM_W-1:0];
        REG_EDGE_THRESHOLD: edge_threshold <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_FRAME_WIDTH:    prdata = {{(PDATA_W-DIM_W){1'b0}}, frame_width};
      REG_FRAME_HEIGHT:   prdata = {{(PDATA_W-DIM_W){1'b0}}, frame_height};
      REG_EDGE_THRESHOLD: prdata = {{(PDATA_W-DIM_W){1'b0}}, edge_threshold};
      default:            prdata = '0;
    endcase
  end

  // out of range sizes are clamped
  always_comb begin
    if (frame_width < DIM_MIN) begin
      width_eff = DIM_MIN;
    end else if (frame_width > WIDTH_MAX) begin
      width_eff = WIDTH_MAX;
    end else begin
      width_eff = frame_width;
    end
    if (frame_height < DIM_MIN) begin
      height_eff = DIM_MIN;
    end else if (frame_height > HEIGHT_MAX) begin
      height_eff = HEIGHT_MAX;
    end else begin
      height_eff = frame_height;
    end
  end

  // position of the incoming pixel, with wrap after a size change
  always_comb begin
    row_inc = row_count + 1'b1;
    if (column_count >= width_eff) begin
      col_adj = '0;
      row_tmp = row_inc;
    end else begin
      col_adj = column_count;
      row_tmp = row_count;
    end
    row_adj = (row_tmp >= height_eff) ? '0 : row_tmp;
    col_inc = col_adj + 1'b1;
    if (col_inc >= width_eff) begin
      column_count_next = '0;
      row_count_next    = ((row_adj + 1'b1) >= height_eff) ? '0 : row_adj + 1'b1;
    end else begin
      column_count_next = col_inc;
      row_count_next    = row_adj;
    end
  end

  assign in_flight    = FIFO_CNT_W'(s1_valid) + FIFO_CNT_W'(s2_valid) + fifo_count;
  assign pixel_stall  = (in_flight >= FIFO_CNT_W'(FIFO_DEPTH));
  assign pixel_accept = pixel_valid && !pixel_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (pixel_accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // line store: read on accept, write back in the following cycle
  // consecutive beats never share a column, so no forwarding is needed
  always_ff @(posedge clk) begin
    if (pixel_accept) begin
      line_rdata <= line_store[col_adj[ADDR_W-1:0]];
    end
    if (s1_valid) begin
      line_store[s1_addr] <= {line_rdata[7:0], s1_pixel};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= pixel_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_accept) begin
      s1_pixel <= gray_pixel;
      s1_addr  <= col_adj[ADDR_W-1:0];
      s1_emit  <= (row_adj >= DIM_W'(2)) && (col_adj >= DIM_W'(2));
      s1_col   <= col_adj[POS_W-1:0] - 1'b1;
      s1_row   <= row_adj[POS_W-1:0] - 1'b1;
      s1_end   <= (row_adj == height_eff - 1'b1) && (col_adj == width_eff - 1'b1);
    end
  end

  // window and gradients
  assign new_col = {line_rdata, s1_pixel};

  assign sum_right  = {2'b0, new_col[23:16]} + {1'b0, new_col[15:8], 1'b0}
                    + {2'b0, new_col[7:0]};
  assign sum_left   = {2'b0, win_left[23:16]} + {1'b0, win_left[15:8], 1'b0}
                    + {2'b0, win_left[7:0]};
  assign sum_top    = {2'b0, win_left[23:16]} + {1'b0, win_centre[23:16], 1'b0}
                    + {2'b0, new_col[23:16]};
  assign sum_bottom = {2'b0, win_left[7:0]} + {1'b0, win_centre[7:0], 1'b0}
                    + {2'b0, new_col[7:0]};
  assign grad_x = $signed({1'b0, sum_right}) - $signed({1'b0, sum_left});
  assign grad_y = $signed({1'b0, sum_top}) - $signed({1'b0, sum_bottom});

  always_ff @(posedge clk) begin
    if (rst) begin
      win_left   <= '0;
      win_centre <= '0;
    end else if (s1_valid) begin
      win_left   <= win_centre;
      win_centre <= new_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_gx  <= grad_x;
      s2_gy  <= grad_y;
      s2_col <= s1_col;
      s2_row <= s1_row;
      s2_end <= s1_end;
    end
  end

  // magnitude and threshold
  assign neg_x    = -s2_gx;
  assign neg_y    = -s2_gy;
  assign abs_x    = s2_gx[10] ? neg_x[9:0] : s2_gx[9:0];
  assign abs_y    = s2_gy[10] ? neg_y[9:0] : s2_gy[9:0];
  assign grad_sum = {1'b0, abs_x} + {1'b0, abs_y};

  always_comb begin
    s2_result.edge_value    = (grad_sum > edge_threshold) ? EDGE_ON : EDGE_OFF;
    s2_result.center_column = s2_col;
    s2_result.center_row    = s2_row;
    s2_result.frame_end     = s2_end;
  end

  sbl_result_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (s2_valid),
    .push_data  (s2_result),
    .pop_stall  (edge_stall),
    .head_valid (edge_valid),
    .head_data  (head_data),
    .count      (fifo_count)
  );

  assign edge_value    = head_data.edge_value;
  assign center_column = head_data.center_column;
  assign center_row    = head_data.center_row;
  assign frame_end     = head_data.frame_end;

endmodule

@@ hdl/sbl_port_checker.sv @@
// port checks on the result channel of the sobel edge detector, with bind
module sbl_port_checker import sbl_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             edge_valid,
  input logic             edge_stall,
  input logic [PIX_W-1:0] edge_value,
  input logic [POS_W-1:0] center_column,
  input logic [POS_W-1:0] center_row,
  input logic             frame_end
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    edge_valid && edge_stall |=> edge_valid && $stable(edge_value)
      && $stable(center_column) && $stable(center_row) && $stable(frame_end))
    else $error("stalled result beat changed");

  // verdict is all ones or all zeros
  a_binary: assert property (@(posedge clk) disable iff (rst)
    edge_valid |-> (edge_value == EDGE_ON) || (edge_value == EDGE_OFF))
    else $error("edge value not binary");

  // only interior pixels are judged
  a_interior: assert property (@(posedge clk) disable iff (rst)
    edge_valid |-> (center_column != '0) && (center_row != '0))
    else $error("border pixel judged");

  // reset empties the result channel
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !edge_valid)
    else $error("result beat after reset");

endmodule

bind sobel_edge_threshold_stream_top sbl_port_checker u_port_checker (
  .clk           (clk),
  .rst           (rst),
  .edge_valid    (edge_valid),
  .edge_stall    (edge_stall),
  .edge_value    (edge_value),
  .center_column (center_column),
  .center_row    (center_row),
  .frame_end     (frame_end)
);
